/* src/skms_pkg.sv */
// ----------------------------------------------------------------------------
// skms_pkg
// Shared constants for the stable key merge sorter.
// ----------------------------------------------------------------------------
package skms_pkg;

    // Fixed field widths of the item payloads.
    localparam int KEY_W     = 31;
    localparam int OUT_IDX_W = 10;

    // Action codes of an input item.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

endpackage

/* src/skms_ram.sv */
// ----------------------------------------------------------------------------
// skms_ram
// Simple memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module skms_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
    input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
    output logic [WIDTH-1:0]         rd_a_data,
    output logic [WIDTH-1:0]         rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered reads; read data holds while rd_en is low.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_data <= mem[rd_a_addr];
            rd_b_data <= mem[rd_b_addr];
        end
    end

endmodule

/* src/skms_cmp.sv */
// ----------------------------------------------------------------------------
// skms_cmp
// Merge decision: whether the right-run head goes out before the left one.
// ----------------------------------------------------------------------------
module skms_cmp
    import skms_pkg::*;
#(
    parameter int IW = 10
) (
    input  logic             left_empty,
    input  logic             right_empty,
    input  logic [KEY_W-1:0] key_left,
    input  logic [KEY_W-1:0] key_right,
    input  logic [IW-1:0]    idx_left,
    input  logic [IW-1:0]    idx_right,
    output logic             take_right
);

    logic right_first;

    // Strict order on key, then arrival index, so the result is stable.
    assign right_first = (key_right < key_left) ||
                         ((key_right == key_left) && (idx_right < idx_left));
    assign take_right  = left_empty || (!right_empty && right_first);

endmodule

/* src/stable_key_merge_sorter_core.sv */
// ----------------------------------------------------------------------------
// stable_key_merge_sorter_core
// Loads keys, sorts their arrival indices stably by key, returns them.
// ----------------------------------------------------------------------------
// Usage:
// An input item with action load stores one key at the next arrival index;
// last_key on a load starts the sort. A load after a finished sort begins a
// new list, and loads beyond MAX_ITEMS keys are dropped. An input item with
// action fetch gives one result item: the next sorted entry, or valid_res 0
// once nothing is left or before a sort has run.
// A fetch passes the order memory read, the key memory read and the output
// register before its result shows; an empty fetch shows in the next cycle.
// The sort is a bottom-up merge with one shared compare unit: each element
// of a pass goes through the source read, key read and compare states, and
// s_ready stays low throughout. The result sits in an output register; while
// the receiver stalls it holds, and no new item is taken until it has gone.
// Reset empties the list and the output register; the memories are not
// cleared, and no clearing pass runs.
// ----------------------------------------------------------------------------
module stable_key_merge_sorter_core
    import skms_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [KEY_W-1:0]     s_key,
    input  logic                 s_last_key,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_IDX_W-1:0] m_arrival_index,
    output logic [KEY_W-1:0]     m_sorted_key,
    output logic                 m_final_entry,
    output logic                 m_valid_res
);

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SRD  = 3'd1;
    localparam logic [2:0] ST_KRD  = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_FRD  = 3'd4;
    localparam logic [2:0] ST_FKEY = 3'd5;
    localparam logic [2:0] ST_FOUT = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rp_reg, rp_next;
    logic          sorted_reg, sorted_next;
    logic          sel_reg, sel_next;
    logic [SW-1:0] w_reg, w_next;
    logic [SW-1:0] i_reg, i_next;
    logic [SW-1:0] j_reg, j_next;
    logic [SW-1:0] k_reg, k_next;
    logic [SW-1:0] mid_reg, mid_next;
    logic [SW-1:0] hi_reg, hi_next;

    logic                 m_valid_reg, m_valid_next;
    logic [OUT_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [KEY_W-1:0]     out_key_reg, out_key_next;
    logic                 out_final_reg, out_final_next;
    logic                 out_vres_reg, out_vres_next;

    logic          in_accept;
    logic [CW-1:0] eff_cnt;
    logic          load_store;
    logic [CW-1:0] load_cnt;

    // Memory ports.
    logic          a_wr_en, b_wr_en, ord_rd_en, key_rd_en;
    logic [IW-1:0] a_wr_addr, b_wr_addr, ord_rd_a, ord_rd_b;
    logic [IW-1:0] a_wr_data, b_wr_data;
    logic [IW-1:0] a_rd_a, a_rd_b, b_rd_a, b_rd_b;
    logic [IW-1:0] src_i_idx, src_j_idx;
    logic [IW-1:0] key_rd_a, key_rd_b;
    logic [KEY_W-1:0] key_a_data, key_b_data;
    logic          take_right;
    logic [IW-1:0] pick_idx;
    logic [SW-1:0] n_sw;
    logic [SW-1:0] w_dbl;

    // Upper bound of a run, clipped to the list length.
    function automatic logic [SW-1:0] clip(input logic [SW-1:0] a,
                                           input logic [SW-1:0] n);
        return (a > n) ? n : a;
    endfunction

    assign in_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE) && !m_valid_reg;
    assign eff_cnt   = sorted_reg ? '0 : cnt_reg;
    assign load_store = in_accept && (s_action == ACT_LOAD) &&
                        (eff_cnt < CW'(MAX_ITEMS));
    assign load_cnt  = load_store ? eff_cnt + CW'(1) : eff_cnt;
    assign n_sw      = SW'(cnt_reg);
    assign w_dbl     = w_reg << 1;

    // Source buffer heads and the chosen entry.
    assign src_i_idx = sel_reg ? b_rd_a : a_rd_a;
    assign src_j_idx = sel_reg ? b_rd_b : a_rd_b;
    assign pick_idx  = take_right ? src_j_idx : src_i_idx;

    // Memory control.
    always_comb begin
        ord_rd_en = (state_reg == ST_SRD) || (state_reg == ST_FRD);
        key_rd_en = (state_reg == ST_KRD) || (state_reg == ST_FKEY);
        ord_rd_a  = (state_reg == ST_FRD) ? rp_reg[IW-1:0] : i_reg[IW-1:0];
        ord_rd_b  = j_reg[IW-1:0];
        key_rd_a  = src_i_idx;
        key_rd_b  = src_j_idx;
        a_wr_en   = load_store || ((state_reg == ST_CMP) && sel_reg);
        a_wr_addr = load_store ? eff_cnt[IW-1:0] : k_reg[IW-1:0];
        a_wr_data = load_store ? eff_cnt[IW-1:0] : pick_idx;
        b_wr_en   = (state_reg == ST_CMP) && !sel_reg;
        b_wr_addr = k_reg[IW-1:0];
        b_wr_data = pick_idx;
    end

    // Sequencer for loading, merging passes and fetching.
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rp_next        = rp_reg;
        sorted_next    = sorted_reg;
        sel_next       = sel_reg;
        w_next         = w_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        out_idx_next   = out_idx_reg;
        out_key_next   = out_key_reg;
        out_final_next = out_final_reg;
        out_vres_next  = out_vres_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_action == ACT_LOAD)) begin
                    cnt_next    = load_cnt;
                    rp_next     = '0;
                    sorted_next = 1'b0;
                    if (s_last_key) begin
                        sel_next = 1'b0;
                        if (load_cnt <= CW'(1)) begin
                            sorted_next = 1'b1;
                        end else begin
                            w_next     = SW'(1);
                            i_next     = '0;
                            k_next     = '0;
                            mid_next   = clip(SW'(1), SW'(load_cnt));
                            j_next     = clip(SW'(1), SW'(load_cnt));
                            hi_next    = clip(SW'(2), SW'(load_cnt));
                            state_next = ST_SRD;
                        end
                    end
                end else if (in_accept) begin
                    if (sorted_reg && (rp_reg < cnt_reg)) begin
                        state_next = ST_FRD;
                    end else begin
                        m_valid_next   = 1'b1;
                        out_idx_next   = '0;
                        out_key_next   = '0;
                        out_final_next = 1'b0;
                        out_vres_next  = 1'b0;
                    end
                end
            end
            ST_SRD: begin
                state_next = ST_KRD;
            end
            ST_KRD: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = ST_SRD;
                k_next = k_reg + SW'(1);
                if (take_right) begin
                    j_next = j_reg + SW'(1);
                end else begin
                    i_next = i_reg + SW'(1);
                end
                if (k_reg + SW'(1) == hi_reg) begin
                    if (hi_reg == n_sw) begin
                        // End of a pass: the written buffer becomes the source.
                        sel_next = !sel_reg;
                        if (w_dbl >= n_sw) begin
                            sorted_next = 1'b1;
                            rp_next     = '0;
                            state_next  = ST_IDLE;
                        end else begin
                            w_next   = w_dbl;
                            i_next   = '0;
                            k_next   = '0;
                            mid_next = clip(w_dbl, n_sw);
                            j_next   = clip(w_dbl, n_sw);
                            hi_next  = clip(w_dbl << 1, n_sw);
                        end
                    end else begin
                        // Next pair of runs within the pass.
                        i_next   = hi_reg;
                        k_next   = hi_reg;
                        mid_next = clip(hi_reg + w_reg, n_sw);
                        j_next   = clip(hi_reg + w_reg, n_sw);
                        hi_next  = clip(hi_reg + w_dbl, n_sw);
                    end
                end
            end
            ST_FRD: begin
                state_next = ST_FKEY;
            end
            ST_FKEY: begin
                state_next = ST_FOUT;
            end
            ST_FOUT: begin
                m_valid_next   = 1'b1;
                out_idx_next   = OUT_IDX_W'(src_i_idx);
                out_key_next   = key_a_data;
                out_final_next = (rp_reg + CW'(1) == cnt_reg);
                out_vres_next  = 1'b1;
                rp_next        = rp_reg + CW'(1);
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rp_reg      <= '0;
            sorted_reg  <= 1'b0;
            sel_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rp_reg      <= rp_next;
            sorted_reg  <= sorted_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Merge position and output payload registers.
    always_ff @(posedge aclk) begin
        w_reg         <= w_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        mid_reg       <= mid_next;
        hi_reg        <= hi_next;
        out_idx_reg   <= out_idx_next;
        out_key_reg   <= out_key_next;
        out_final_reg <= out_final_next;
        out_vres_reg  <= out_vres_next;
    end

    skms_ram #(.DEPTH(MAX_ITEMS), .WIDTH(KEY_W)) u_key_store (
        .aclk      (aclk),
        .wr_en     (load_store),
        .wr_addr   (eff_cnt[IW-1:0]),
        .wr_data   (s_key),
        .rd_en     (key_rd_en),
        .rd_a_addr (key_rd_a),
        .rd_b_addr (key_rd_b),
        .rd_a_data (key_a_data),
        .rd_b_data (key_b_data)
    );

    skms_ram #(.DEPTH(MAX_ITEMS), .WIDTH(IW)) u_order_a (
        .aclk      (aclk),
        .wr_en     (a_wr_en),
        .wr_addr   (a_wr_addr),
        .wr_data   (a_wr_data),
        .rd_en     (ord_rd_en),
        .rd_a_addr (ord_rd_a),
        .rd_b_addr (ord_rd_b),
        .rd_a_data (a_rd_a),
        .rd_b_data (a_rd_b)
    );

    skms_ram #(.DEPTH(MAX_ITEMS), .WIDTH(IW)) u_order_b (
        .aclk      (aclk),
        .wr_en     (b_wr_en),
        .wr_addr   (b_wr_addr),
        .wr_data   (b_wr_data),
        .rd_en     (ord_rd_en),
        .rd_a_addr (ord_rd_a),
        .rd_b_addr (ord_rd_b),
        .rd_a_data (b_rd_a),
        .rd_b_data (b_rd_b)
    );

    skms_cmp #(.IW(IW)) u_cmp (
        .left_empty  (i_reg >= mid_reg),
        .right_empty (j_reg >= hi_reg),
        .key_left    (key_a_data),
        .key_right   (key_b_data),
        .idx_left    (src_i_idx),
        .idx_right   (src_j_idx),
        .take_right  (take_right)
    );

    assign m_valid         = m_valid_reg;
    assign m_arrival_index = out_idx_reg;
    assign m_sorted_key    = out_key_reg;
    assign m_final_entry   = out_final_reg;
    assign m_valid_res     = out_vres_reg;

    // A fetch item with an entry left always enters the read sequence.
    a_fetch_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (s_action == ACT_FETCH) && sorted_reg && (rp_reg < cnt_reg))
        |=> (state_reg == ST_FRD))
        else $error("fetch did not start the read sequence");

    // A returned entry is only shown once the list has been sorted.
    a_vres_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_vres_reg) |-> sorted_reg)
        else $error("entry returned from an unsorted list");

    // Merge positions stay inside the list during a pass.
    a_merge_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> ((k_reg < hi_reg) && (hi_reg <= n_sw)))
        else $error("merge position outside the list");

    // The read pointer never passes the list length.
    a_rp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rp_reg <= cnt_reg)
        else $error("read pointer beyond loaded count");

endmodule

/* bench/tb_stable_key_merge_sorter_core.sv */
// ----------------------------------------------------------------------------
// tb_stable_key_merge_sorter_core
// Self-checking bench for the stable key merge sorter core.
// Lists of keys are loaded and then fetched back under varying idle and stall
// patterns. A behavioural model of the list predicts each fetch result, and a
// monitor compares every returned item field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_stable_key_merge_sorter_core;
    import skms_pkg::*;

    localparam int CAPACITY    = 1024;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int KEY_MAX     = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] arrival_index;
        logic [KEY_W-1:0]     sorted_key;
        logic                 final_entry;
        logic                 valid_res;
    } fetch_result_t;

    typedef enum logic {NO = 1'b0, YES = 1'b1} bool_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_action = ACT_LOAD;
    logic [KEY_W-1:0]     s_key = '0;
    logic                 s_last_key = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [OUT_IDX_W-1:0] m_arrival_index;
    logic [KEY_W-1:0]     m_sorted_key;
    logic                 m_final_entry;
    logic                 m_valid_res;

    // Model state of the list.
    logic [KEY_W-1:0]     list_keys [CAPACITY];
    int                   sorted_order [CAPACITY];
    int                   list_len = 0;
    int                   fetch_pos = 0;
    bool_t                list_sorted;

    fetch_result_t        pending_results [$];
    int                   idle_pct = 0;
    int                   stall_pct = 0;
    int                   mismatches = 0;
    int                   results_seen = 0;
    int                   loads_sent = 0;
    int                   fetches_sent = 0;
    int                   sorts_seen = 0;
    int                   cycles = 0;

    stable_key_merge_sorter_core #(.MAX_ITEMS(CAPACITY)) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_key           (s_key),
        .s_last_key      (s_last_key),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_arrival_index (m_arrival_index),
        .m_sorted_key    (m_sorted_key),
        .m_final_entry   (m_final_entry),
        .m_valid_res     (m_valid_res)
    );

    // Clock generation, 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_stable_key_merge_sorter_core: done, errors");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Stable ordering: lower key first, then lower arrival index.
    function automatic bit entry_precedes(int a, int b);
        return list_keys[a] < list_keys[b] ||
               (list_keys[a] == list_keys[b] && a < b);
    endfunction

    // Sorts the arrival indices of the loaded list.
    function automatic void sort_list();
        int j;
        int cur;
        for (int t = 0; t < list_len; t++) begin
            cur = t;
            j = t - 1;
            while (j >= 0 && entry_precedes(cur, sorted_order[j])) begin
                sorted_order[j + 1] = sorted_order[j];
                j--;
            end
            sorted_order[j + 1] = cur;
        end
        fetch_pos = 0;
        list_sorted = YES;
        sorts_seen++;
    endfunction

    // Updates the model for one accepted item, queueing any result.
    function automatic void predict_item(logic act, logic [KEY_W-1:0] key, logic last);
        fetch_result_t res;
        if (act == ACT_LOAD) begin
            if (list_sorted == YES) begin
                list_len = 0;
                fetch_pos = 0;
                list_sorted = NO;
            end
            if (list_len < CAPACITY) begin
                list_keys[list_len] = key;
                list_len++;
            end
            if (last)
                sort_list();
        end else begin
            res = '0;
            if (list_sorted == YES && fetch_pos < list_len) begin
                res.arrival_index = sorted_order[fetch_pos][OUT_IDX_W-1:0];
                res.sorted_key    = list_keys[sorted_order[fetch_pos]];
                res.final_entry   = (fetch_pos + 1 == list_len);
                res.valid_res     = 1'b1;
                fetch_pos++;
            end
            pending_results.push_back(res);
        end
    endfunction

    // Result monitor: compares each returned item with the oldest prediction.
    always @(posedge aclk) begin
        fetch_result_t want;
        fetch_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_arrival_index, m_sorted_key, m_final_entry, m_valid_res};
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: idx %0d key %0h final %0b valid %0b",
                             got.arrival_index, got.sorted_key, got.final_entry,
                             got.valid_res);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected idx %0d key %0h final %0b valid %0b, %s",
                                 want.arrival_index, want.sorted_key, want.final_entry,
                                 want.valid_res,
                                 $sformatf("got idx %0d key %0h final %0b valid %0b",
                                           got.arrival_index, got.sorted_key,
                                           got.final_entry, got.valid_res));
                end
            end
        end
    end

    // Sends one item, with random idle cycles ahead of it.
    task automatic send_item(logic act, logic [KEY_W-1:0] key, logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_key      <= key;
        s_last_key <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_item(act, key, last);
        if (act == ACT_LOAD)
            loads_sent++;
        else
            fetches_sent++;
    endtask

    task automatic load_key(logic [KEY_W-1:0] key, logic last);
        send_item(ACT_LOAD, key, last);
    endtask

    task automatic fetch_entry();
        send_item(ACT_FETCH, KEY_W'($urandom), 1'($urandom));
    endtask

    // Holds the sender off until every predicted result has been returned.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Directed cases: empty fetches, extremes, ties and list restart.
    task automatic test_directed();
        fetch_entry();
        load_key(KEY_W'(KEY_MAX), 1'b1);
        fetch_entry();
        fetch_entry();
        load_key(KEY_W'(KEY_MAX), 1'b0);
        load_key('0, 1'b0);
        load_key(KEY_W'(5), 1'b0);
        load_key('0, 1'b0);
        load_key(KEY_W'(KEY_MAX), 1'b0);
        load_key(KEY_W'(5), 1'b1);
        repeat (7)
            fetch_entry();
        // A load after a sort begins a fresh list, even mid-fetch.
        load_key(KEY_W'(3), 1'b0);
        load_key(KEY_W'(1), 1'b1);
        fetch_entry();
        load_key(KEY_W'(9), 1'b1);
        fetch_entry();
        fetch_entry();
        wait_for_drain();
    endtask

    // Fills the list past capacity; the dropped load still starts the sort.
    // Only the head of the sorted list is fetched back.
    task automatic test_capacity();
        for (int n = 0; n < CAPACITY; n++)
            load_key(KEY_W'($urandom_range(300)), 1'b0);
        load_key(KEY_W'($urandom), 1'b1);
        repeat (16)
            fetch_entry();
        wait_for_drain();
    endtask

    // Random lists with random content, plus some noise items.
    task automatic test_random_lists(int budget, int idle, int stall);
        int sent;
        int len;
        int extra;
        int key_span;
        idle_pct  = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < budget) begin
            len = $urandom_range(16, 1);
            case ($urandom_range(2))
                0: key_span = 3;
                1: key_span = 40;
                default: key_span = KEY_MAX;
            endcase
            if ($urandom_range(9) == 0) begin
                fetch_entry();
                sent++;
            end
            for (int n = 0; n < len; n++)
                load_key(KEY_W'($urandom_range(key_span)), (n == len - 1));
            sent += len;
            if ($urandom_range(9) == 0) begin
                extra = $urandom_range(len);
                len = 0;
            end else begin
                extra = $urandom_range(2);
            end
            repeat (len + extra)
                fetch_entry();
            sent += len + extra;
        end
        wait_for_drain();
    endtask

    initial begin
        list_sorted = NO;
        repeat (11)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_capacity();
        test_random_lists(85, 0, 0);
        test_random_lists(85, 71, 0);
        test_random_lists(85, 0, 71);
        test_random_lists(85, 25, 25);

        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (50)
            @(posedge aclk);

        $display("covered %0d loads, %0d fetches, %0d sorted lists, %0d results checked",
                 loads_sent, fetches_sent, sorts_seen, results_seen);
        $display("mismatching result items: %0d", mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb_stable_key_merge_sorter_core: done, clean");
        end else begin
            $display("tb_stable_key_merge_sorter_core: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
src/skms_pkg.sv
src/skms_ram.sv
src/skms_cmp.sv
src/stable_key_merge_sorter_core.sv
bench/tb_stable_key_merge_sorter_core.sv
